// ===== rtl/lrfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrfd_pkg
// Shared types, constants and helpers of the four-direction run tracker.
// ----------------------------------------------------------------------------
package lrfd_pkg;

   localparam int unsigned LINE_DEPTH = 1024;
   localparam int unsigned ADDR_W     = 10;
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned RUN_W      = 11;
   localparam int unsigned SIDE_W     = 11;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 11;

   localparam logic [SIDE_W-1:0] RESET_GRID_WIDTH  = 11'd8;
   localparam logic [SIDE_W-1:0] RESET_GRID_HEIGHT = 11'd8;
   localparam logic [PIX_W-1:0]  RESET_MARK_CODE   = 8'd35;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_MARK_CODE   = 2'd2
   } csr_index_type;

   // one line store entry: byte and the three runs that end at it
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [RUN_W-1:0] vrun;
      logic [RUN_W-1:0] drun;
      logic [RUN_W-1:0] arun;
   } line_entry_type;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (v > SIDE_W'(LINE_DEPTH)) begin
         r = SIDE_W'(LINE_DEPTH);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/lrfd_if.sv =====
// ----------------------------------------------------------------------------
// lrfd channel interfaces
// Valid/ready channels for grid bytes in and frame results out.
// ----------------------------------------------------------------------------
interface lrfd_req_if;
   logic                        valid;
   logic                        ready;
   logic [lrfd_pkg::PIX_W-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface lrfd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lrfd_pkg::RUN_W-1:0]  longest_other;
   logic [lrfd_pkg::RUN_W-1:0]  longest_marked;

   modport source (output valid, output longest_other, output longest_marked, input ready);
   modport sink   (input valid, input longest_other, input longest_marked, output ready);
endinterface

// ===== rtl/lrfd_tap_cell.sv =====
// ----------------------------------------------------------------------------
// lrfd_tap_cell
// One window cell over the previous row; takes its neighbor's entry per beat.
// ----------------------------------------------------------------------------
module lrfd_tap_cell (
   input  logic                     clock,
   input  logic                     shift_en,
   input  lrfd_pkg::line_entry_type entry_in,
   output lrfd_pkg::line_entry_type entry_out
);
   import lrfd_pkg::*;

   line_entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

// ===== rtl/lrfd_run_cell.sv =====
// ----------------------------------------------------------------------------
// lrfd_run_cell
// Extends a run when the byte matches its neighbor, saturating at the cap.
// ----------------------------------------------------------------------------
module lrfd_run_cell #(
   parameter int unsigned RunCap = 1024
) (
   input  logic                        has_neighbor,
   input  logic [lrfd_pkg::PIX_W-1:0]  pixel,
   input  logic [lrfd_pkg::PIX_W-1:0]  neighbor_pixel,
   input  logic [lrfd_pkg::RUN_W-1:0]  prior_run,
   output logic [lrfd_pkg::RUN_W-1:0]  run
);
   import lrfd_pkg::*;

   localparam logic [RUN_W-1:0] CapVal = RUN_W'(RunCap);

   logic [RUN_W-1:0] extended;

   assign extended = (prior_run < CapVal) ? prior_run + RUN_W'(1) : CapVal;

   always_comb begin
      if (has_neighbor && (pixel == neighbor_pixel)) begin
         run = extended;
      end else begin
         run = RUN_W'(1);
      end
   end

endmodule

// ===== rtl/lrfd_line_store.sv =====
// ----------------------------------------------------------------------------
// lrfd_line_store
// Previous-row store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lrfd_line_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [lrfd_pkg::ADDR_W-1:0] wr_addr,
   input  lrfd_pkg::line_entry_type    wr_data,
   input  logic                        rd_en,
   input  logic [lrfd_pkg::ADDR_W-1:0] rd_addr,
   output lrfd_pkg::line_entry_type    rd_data
);
   import lrfd_pkg::*;

   line_entry_type mem [LINE_DEPTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/longest_run_four_directions_core.sv =====
// ----------------------------------------------------------------------------
// longest_run_four_directions_core
// Longest run of equal bytes in four directions over a raster-order grid.
//
// req_chan carries one grid byte per beat in raster order; after the last
// byte of a frame one beat on rsp_chan carries the longest unmarked run and
// the longest run of the mark byte, and the frame maxima clear.
// csr_* writes grid width, grid height and mark code (index 0, 1, 2); the
// user must write them only while idle (the block does not enforce it);
// a width or height write restarts the frame. Throughput: one byte per
// cycle. The last byte of a frame is held off while an earlier result is
// still unread or still in the maximum stage. After the last byte is taken,
// the result passes through the maximum stage into the output register.
// The previous row sits in a 1024-entry line store read one column ahead;
// tap cells hold the up and up-left entries; up-right is the read or ovr_ff.
// Reset: 8 x 8 grid, mark code 35, position and maxima cleared; the line
// store needs no clearing pass and bytes are taken right after reset.
// A stalled rsp_chan holds the result; bytes keep flowing until the next
// frame's last byte.
// ----------------------------------------------------------------------------
module longest_run_four_directions_core #(
   parameter int unsigned MAX_SIDE = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   lrfd_req_if.sink                        req_chan,
   lrfd_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [lrfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lrfd_pkg::CSR_DATA_W-1:0] csr_data
);
   import lrfd_pkg::*;

   localparam int unsigned RUN_CAP = (MAX_SIDE < 2047) ? MAX_SIDE : 2047;

   // configuration
   logic [SIDE_W-1:0] grid_width_ff;
   logic [SIDE_W-1:0] grid_height_ff;
   logic [PIX_W-1:0]  mark_code_ff;
   logic              restart;

   // position and horizontal state
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0]  left_ff;
   logic [RUN_W-1:0]  hrun_ff;

   // window over the previous row
   line_entry_type    row0_ff, row1_ff, ovr_ff;
   logic              sel_ff;
   line_entry_type    mem_rdata, up_right, up_entry, up_left, cur_d, new_entry;

   logic              req_fire, col_last, row_last, frame_last;
   logic              has_above, not_first_col, has_right;
   logic [RUN_W-1:0]  hr, vr, dr, ar;

   // maximum stage
   logic              s2_valid_ff, s2_last_ff, s2_mark_ff;
   logic [RUN_W-1:0]  s2_hr_ff, s2_vr_ff, s2_dr_ff, s2_ar_ff;
   logic [RUN_W-1:0]  m01, m23, best, mo_upd, mm_upd;
   logic [RUN_W-1:0]  max_other_ff, max_other_in, max_marked_ff, max_marked_in;
   logic              out_load;

   // output register
   logic              o_valid_ff, o_valid_in;
   logic [RUN_W-1:0]  o_other_ff, o_marked_ff;

   assign req_fire      = req_chan.valid & req_chan.ready;
   assign col_last      = (({1'b0, col_ff} + SIDE_W'(1)) == grid_width_ff);
   assign row_last      = (({1'b0, row_ff} + SIDE_W'(1)) == grid_height_ff);
   assign frame_last    = col_last & row_last;
   assign has_above     = (row_ff != '0);
   assign not_first_col = (col_ff != '0);
   assign has_right     = ~col_last;
   assign restart       = csr_write_en &&
                          ((csr_index == CSR_GRID_WIDTH) || (csr_index == CSR_GRID_HEIGHT));

   assign req_chan.ready = ~frame_last |
                           ((~o_valid_ff | rsp_chan.ready) & ~(s2_valid_ff & s2_last_ff));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= RESET_GRID_WIDTH;
         grid_height_ff <= RESET_GRID_HEIGHT;
         mark_code_ff   <= RESET_MARK_CODE;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_WIDTH:  grid_width_ff  <= clamp_side(csr_data);
            CSR_GRID_HEIGHT: grid_height_ff <= clamp_side(csr_data);
            CSR_MARK_CODE:   mark_code_ff   <= csr_data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ADDR_W'(1);
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         sel_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (req_fire) begin
            sel_ff <= col_last;
         end
      end
   end

   // line store and window
   lrfd_line_store u_line_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (col_ff),
      .wr_data (new_entry),
      .rd_en   (req_fire),
      .rd_addr (col_ff + ADDR_W'(2)),
      .rd_data (mem_rdata)
   );

   assign up_right = sel_ff ? ovr_ff : mem_rdata;

   always_comb begin
      if (!col_last) begin
         cur_d = up_right;
      end else if (grid_width_ff == SIDE_W'(1)) begin
         cur_d = new_entry;
      end else begin
         cur_d = row0_ff;
      end
   end

   lrfd_tap_cell u_tap_up (
      .clock     (clock),
      .shift_en  (req_fire),
      .entry_in  (cur_d),
      .entry_out (up_entry)
   );

   lrfd_tap_cell u_tap_up_left (
      .clock     (clock),
      .shift_en  (req_fire),
      .entry_in  (up_entry),
      .entry_out (up_left)
   );

   // left byte, horizontal run and the first two entries of the row just written, for the next row's start
   always_ff @(posedge clock) begin
      if (req_fire) begin
         left_ff <= req_chan.pixel;
         hrun_ff <= hr;
         if (col_ff == ADDR_W'(0)) begin
            row0_ff <= new_entry;
         end
         if (col_ff == ADDR_W'(1)) begin
            row1_ff <= new_entry;
         end
         if (col_last) begin
            ovr_ff <= (grid_width_ff == SIDE_W'(2)) ? new_entry : row1_ff;
         end
      end
   end

   // run cells, one per direction
   lrfd_run_cell #(.RunCap(RUN_CAP)) u_run_horiz (
      .has_neighbor   (not_first_col),
      .pixel          (req_chan.pixel),
      .neighbor_pixel (left_ff),
      .prior_run      (hrun_ff),
      .run            (hr)
   );

   lrfd_run_cell #(.RunCap(RUN_CAP)) u_run_vert (
      .has_neighbor   (has_above),
      .pixel          (req_chan.pixel),
      .neighbor_pixel (up_entry.pixel),
      .prior_run      (up_entry.vrun),
      .run            (vr)
   );

   lrfd_run_cell #(.RunCap(RUN_CAP)) u_run_diag (
      .has_neighbor   (has_above & not_first_col),
      .pixel          (req_chan.pixel),
      .neighbor_pixel (up_left.pixel),
      .prior_run      (up_left.drun),
      .run            (dr)
   );

   lrfd_run_cell #(.RunCap(RUN_CAP)) u_run_anti (
      .has_neighbor   (has_above & has_right),
      .pixel          (req_chan.pixel),
      .neighbor_pixel (up_right.pixel),
      .prior_run      (up_right.arun),
      .run            (ar)
   );

   assign new_entry = '{pixel: req_chan.pixel, vrun: vr, drun: dr, arun: ar};

   // maximum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s2_last_ff <= frame_last;
         s2_mark_ff <= (req_chan.pixel == mark_code_ff);
         s2_hr_ff   <= hr;
         s2_vr_ff   <= vr;
         s2_dr_ff   <= dr;
         s2_ar_ff   <= ar;
      end
   end

   assign m01    = (s2_hr_ff > s2_vr_ff) ? s2_hr_ff : s2_vr_ff;
   assign m23    = (s2_dr_ff > s2_ar_ff) ? s2_dr_ff : s2_ar_ff;
   assign best   = (m01 > m23) ? m01 : m23;
   assign mo_upd = (!s2_mark_ff && (best > max_other_ff)) ? best : max_other_ff;
   assign mm_upd = (s2_mark_ff && (best > max_marked_ff)) ? best : max_marked_ff;
   assign out_load = s2_valid_ff & s2_last_ff;

   always_comb begin
      max_other_in  = max_other_ff;
      max_marked_in = max_marked_ff;
      if (restart || out_load) begin
         max_other_in  = '0;
         max_marked_in = '0;
      end else if (s2_valid_ff) begin
         max_other_in  = mo_upd;
         max_marked_in = mm_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_other_ff  <= '0;
         max_marked_ff <= '0;
      end else begin
         max_other_ff  <= max_other_in;
         max_marked_ff <= max_marked_in;
      end
   end

   // output register
   assign o_valid_in = out_load | (o_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_other_ff  <= mo_upd;
         o_marked_ff <= mm_upd;
      end
   end

   assign rsp_chan.valid          = o_valid_ff;
   assign rsp_chan.longest_other  = o_other_ff;
   assign rsp_chan.longest_marked = o_marked_ff;

`ifndef SYNTH
   // a frame end only reaches the output register when it is free
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_last_ff) |-> !o_valid_ff)
      else $error("frame end in maximum stage while result pending");

   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < grid_width_ff))
      else $error("column beyond grid width");

   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, row_ff} < grid_height_ff))
      else $error("row beyond grid height");

   // the override entry is only in use at the start of a row
   assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (col_ff == '0))
      else $error("window override selected away from column zero");

   assert property (@(posedge clock) disable iff (reset)
      $rose(o_valid_ff) |-> $past(s2_valid_ff && s2_last_ff))
      else $error("result raised without a frame end");
`endif

endmodule
